FILE: sv/swmq_pkg.sv
package swmq_pkg;

  // sizing
  localparam int VALUE_BITS  = 16;
  localparam int BLOCK_BITS  = 8;
  localparam int STACK_DEPTH = 4096;

  localparam int NUM_VALUES = 1 << VALUE_BITS;
  localparam int NUM_BLOCKS = 1 << BLOCK_BITS;
  localparam int BLK_SHIFT  = (VALUE_BITS > BLOCK_BITS) ? VALUE_BITS - BLOCK_BITS : 0;
  localparam int BLK_SIZE   = 1 << BLK_SHIFT;
  localparam int OFF_W      = BLK_SHIFT + 1;
  localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
  localparam int SP_W       = $clog2(STACK_DEPTH);

  // port field widths
  localparam int DATA_W = 16;
  localparam int REQ_W  = 2;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MEDIAN = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH_RD,
    S_PUSH_WR,
    S_POP_RD,
    S_POP_CNT,
    S_POP_WR,
    S_MB_RD,
    S_MB_CHK,
    S_MV_RD,
    S_MV_CHK,
    S_DONE
  } state_t;

  // access to the two count memories
  typedef struct packed {
    logic                  v_we;
    logic                  b_we;
    logic [VALUE_BITS-1:0] v_addr;
    logic [BLOCK_BITS-1:0] b_addr;
    logic [CNT_W-1:0]      v_wdata;
    logic [CNT_W-1:0]      b_wdata;
  } cnt_req_t;

  function automatic logic [BLOCK_BITS-1:0] block_of(input logic [VALUE_BITS-1:0] v);
    block_of = BLOCK_BITS'(v >> BLK_SHIFT);
  endfunction

endpackage

FILE: sv/stack_with_median_query.sv
// channel  dir  tdata                 tuser
// in       in   [15:0] push_value     [1:0] req_type
// out      out  [15:0] result_value   [1:0] status
//
// push and pop each do a read-modify-write of the count memories.
// a median query walks the block counts, then the value counts in the chosen block,
// one count read and one accumulate per cycle through the shared adder.
// after reset a clearing pass over all NUM_VALUES entries (65536) zeroes the counts;
// no request is taken meanwhile. a finished result waits in the output register
// while the next request is taken; a request finishes only once that register is free.
module stack_with_median_query
  import swmq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [15:0] push_value
  input  logic [REQ_W-1:0]  in_tuser,   // [1:0] req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [15:0] result_value
  output logic [STAT_W-1:0] out_tuser   // [1:0] status
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] clr_r, clr_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [BLOCK_BITS-1:0] blk_r, blk_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic [OFF_W-1:0]      off_r, off_nxt;
  logic [DATA_W-1:0]     res_r, res_nxt;
  logic [STAT_W-1:0]     stat_r, stat_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [STAT_W-1:0]     out_stat_r, out_stat_nxt;

  logic                  stk_we;
  logic [SP_W-1:0]       stk_addr;
  logic [VALUE_BITS-1:0] stk_rdata;
  cnt_req_t              creq;
  logic [CNT_W-1:0]      v_rdata, b_rdata;
  logic                  acc_clr, acc_add, acc_lt;
  logic [CNT_W-1:0]      acc_in;
  logic [CNT_W-1:0]      cnt_dec;
  logic [CNT_W:0]        cnt_inc1;
  logic                  in_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign cnt_dec  = cnt_r - 1'b1;
  assign cnt_inc1 = {1'b0, cnt_r} + 1'b1;

  swmq_stack u_stack (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (val_r),
    .rdata (stk_rdata)
  );

  swmq_counts u_counts (
    .clk     (clk),
    .req     (creq),
    .v_rdata (v_rdata),
    .b_rdata (b_rdata)
  );

  swmq_acc u_acc (
    .clk    (clk),
    .clr    (acc_clr),
    .add    (acc_add),
    .cnt_in (acc_in),
    .k      (k_r),
    .lt     (acc_lt)
  );

  // state and data registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    k_r        <= k_nxt;
    blk_r      <= blk_nxt;
    v_r        <= v_nxt;
    off_r      <= off_nxt;
    res_r      <= res_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    val_nxt       = val_r;
    clr_nxt       = clr_r;
    k_nxt         = k_r;
    blk_nxt       = blk_r;
    v_nxt         = v_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    stat_nxt      = stat_r;
    out_data_nxt  = out_data_r;
    out_stat_nxt  = out_stat_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    stk_we        = 1'b0;
    stk_addr      = cnt_r[SP_W-1:0];
    creq.v_we     = 1'b0;
    creq.b_we     = 1'b0;
    creq.v_addr   = val_r;
    creq.b_addr   = block_of(val_r);
    creq.v_wdata  = v_rdata + 1'b1;
    creq.b_wdata  = b_rdata + 1'b1;
    acc_clr       = 1'b0;
    acc_add       = 1'b0;
    acc_in        = v_rdata;

    unique case (state_r)
      // zero both count memories, one entry a cycle
      S_CLEAR: begin
        creq.v_we    = 1'b1;
        creq.b_we    = 1'b1;
        creq.v_addr  = clr_r;
        creq.b_addr  = BLOCK_BITS'(clr_r);
        creq.v_wdata = '0;
        creq.b_wdata = '0;
        clr_nxt      = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = S_IDLE;
        end
      end

      // take a request and sort out the trivial cases
      S_IDLE: begin
        in_tready = 1'b1;
        val_nxt   = VALUE_BITS'(in_tdata);
        k_nxt     = cnt_inc1[CNT_W:1];
        blk_nxt   = '0;
        acc_clr   = 1'b1;
        res_nxt   = '0;
        stat_nxt  = STAT_OK;
        if (in_fire) begin
          unique case (in_tuser) inside
            REQ_PUSH: begin
              if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
                stat_nxt  = STAT_FULL;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_PUSH_RD;
              end
            end
            REQ_POP, REQ_MEDIAN: begin
              if (cnt_r == '0) begin
                stat_nxt  = STAT_EMPTY;
                state_nxt = S_DONE;
              end else if (in_tuser == REQ_POP) begin
                state_nxt = S_POP_RD;
              end else begin
                state_nxt = S_MB_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // push: store value, read both counts
      S_PUSH_RD: begin
        stk_we    = 1'b1;
        state_nxt = S_PUSH_WR;
      end

      S_PUSH_WR: begin
        creq.v_we = 1'b1;
        creq.b_we = 1'b1;
        cnt_nxt   = cnt_inc1[CNT_W-1:0];
        state_nxt = S_DONE;
      end

      // pop: read top entry
      S_POP_RD: begin
        stk_addr  = cnt_dec[SP_W-1:0];
        cnt_nxt   = cnt_dec;
        state_nxt = S_POP_CNT;
      end

      S_POP_CNT: begin
        creq.v_addr = stk_rdata;
        creq.b_addr = block_of(stk_rdata);
        val_nxt     = stk_rdata;
        res_nxt     = DATA_W'(stk_rdata);
        state_nxt   = S_POP_WR;
      end

      S_POP_WR: begin
        creq.v_we    = 1'b1;
        creq.b_we    = 1'b1;
        creq.v_wdata = v_rdata - 1'b1;
        creq.b_wdata = b_rdata - 1'b1;
        state_nxt    = S_DONE;
      end

      // median: walk block counts
      S_MB_RD: begin
        creq.b_addr = blk_r;
        state_nxt   = S_MB_CHK;
      end

      S_MB_CHK: begin
        acc_in      = b_rdata;
        creq.b_addr = blk_r + 1'b1;
        if (acc_lt) begin
          acc_add = 1'b1;
          blk_nxt = blk_r + 1'b1;
          if (blk_r == BLOCK_BITS'(NUM_BLOCKS - 1)) begin
            state_nxt = S_DONE;
          end
        end else begin
          v_nxt     = VALUE_BITS'(blk_r) << BLK_SHIFT;
          off_nxt   = '0;
          state_nxt = S_MV_RD;
        end
      end

      // median: walk value counts inside the chosen block
      S_MV_RD: begin
        creq.v_addr = v_r;
        state_nxt   = S_MV_CHK;
      end

      S_MV_CHK: begin
        acc_in      = v_rdata;
        creq.v_addr = v_r + 1'b1;
        if (acc_lt) begin
          acc_add = 1'b1;
          v_nxt   = v_r + 1'b1;
          off_nxt = off_r + 1'b1;
          if (off_r == OFF_W'(BLK_SIZE - 1)) begin
            state_nxt = S_DONE;
          end
        end else begin
          res_nxt   = DATA_W'(v_r);
          state_nxt = S_DONE;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_stat_nxt  = stat_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule

FILE: sv/swmq_stack.sv
module swmq_stack
  import swmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  we,
  input  logic [SP_W-1:0]       addr,
  input  logic [VALUE_BITS-1:0] wdata,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [STACK_DEPTH];

  // single port store, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/swmq_counts.sv
module swmq_counts
  import swmq_pkg::*;
(
  input  logic             clk,
  input  cnt_req_t         req,
  output logic [CNT_W-1:0] v_rdata,
  output logic [CNT_W-1:0] b_rdata
);

  logic [CNT_W-1:0] v_mem [NUM_VALUES];
  logic [CNT_W-1:0] b_mem [NUM_BLOCKS];

  // per-value counts
  always_ff @(posedge clk) begin
    if (req.v_we) begin
      v_mem[req.v_addr] <= req.v_wdata;
    end
    v_rdata <= v_mem[req.v_addr];
  end

  // per-block counts
  always_ff @(posedge clk) begin
    if (req.b_we) begin
      b_mem[req.b_addr] <= req.b_wdata;
    end
    b_rdata <= b_mem[req.b_addr];
  end

endmodule

FILE: sv/swmq_acc.sv
module swmq_acc
  import swmq_pkg::*;
(
  input  logic             clk,
  input  logic             clr,
  input  logic             add,
  input  logic [CNT_W-1:0] cnt_in,
  input  logic [CNT_W-1:0] k,
  output logic             lt
);

  logic [CNT_W-1:0] acc_r;
  logic [CNT_W:0]   sum;

  // running total plus the count under test, against the rank
  assign sum = {1'b0, acc_r} + {1'b0, cnt_in};
  assign lt  = sum < {1'b0, k};

  always_ff @(posedge clk) begin
    if (clr) begin
      acc_r <= '0;
    end else if (add) begin
      acc_r <= sum[CNT_W-1:0];
    end
  end

endmodule

FILE: verif/tb_stack_with_median_query.sv
module tb_stack_with_median_query
  import swmq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // unused request code, answered with a zero ok reply
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam int RAND_ITEMS     = 1170;
  localparam int TAIL_ITEMS     = 150;
  localparam int LONG_HOLD_AT   = 200;
  localparam int PAUSE_AT       = 600;
  localparam int LONG_HOLD_CYC  = 2000;
  localparam int SETTLE_CYC     = 600;
  localparam int DIR_ROWS       = 26;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [STAT_W-1:0] stat;
  } reply_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [DATA_W-1:0] value;
    logic              known;
    logic [DATA_W-1:0] exp_res;
    logic [STAT_W-1:0] exp_stat;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [15:0] push_value
  logic [REQ_W-1:0]  in_tuser;   // [1:0] req_type
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [15:0] result_value
  logic [STAT_W-1:0] out_tuser;  // [1:0] status

  // shadow of the stack and its tallies
  logic [DATA_W-1:0] held_vals[$];
  int unsigned       val_tally[NUM_VALUES];
  int unsigned       blk_tally[NUM_BLOCKS];

  reply_t pending_replies[$];
  int     mismatch_cnt = 0;
  int     in_idle_pct  = 20;
  int     out_idle_pct = 20;
  bit     long_hold    = 1'b0;

  // directed rows: known replies where obvious, the rest from the shadow
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_POP,    16'h0000, 1'b1, 16'h0000, STAT_EMPTY},
    '{REQ_MEDIAN, 16'hFFFF, 1'b1, 16'h0000, STAT_EMPTY},
    '{REQ_SPARE,  16'hFFFF, 1'b1, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'h0000, 1'b1, 16'h0000, STAT_OK},
    '{REQ_MEDIAN, 16'h0000, 1'b1, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'hFFFF, 1'b1, 16'h0000, STAT_OK},
    '{REQ_MEDIAN, 16'hFFFF, 1'b1, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'h00FF, 1'b1, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'h0100, 1'b1, 16'h0000, STAT_OK},
    '{REQ_MEDIAN, 16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'hFF00, 1'b1, 16'h0000, STAT_OK},
    '{REQ_MEDIAN, 16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_PUSH,   16'hFFFF, 1'b1, 16'h0000, STAT_OK},
    '{REQ_MEDIAN, 16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_SPARE,  16'h0000, 1'b1, 16'h0000, STAT_OK},
    '{REQ_POP,    16'hFFFF, 1'b1, 16'hFFFF, STAT_OK},
    '{REQ_MEDIAN, 16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_POP,    16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_POP,    16'hFFFF, 1'b0, 16'h0000, STAT_OK},
    '{REQ_POP,    16'h0000, 1'b0, 16'h0000, STAT_OK},
    '{REQ_POP,    16'hFFFF, 1'b0, 16'h0000, STAT_OK},
    '{REQ_POP,    16'h0000, 1'b1, 16'h0000, STAT_OK},
    '{REQ_POP,    16'h0000, 1'b1, 16'h0000, STAT_EMPTY},
    '{REQ_MEDIAN, 16'h0000, 1'b1, 16'h0000, STAT_EMPTY},
    '{REQ_PUSH,   16'h8000, 1'b1, 16'h0000, STAT_OK},
    '{REQ_POP,    16'h0000, 1'b1, 16'h8000, STAT_OK}
  };

  logic [REQ_W-1:0] full_probe [7] = '{
    REQ_PUSH, REQ_PUSH, REQ_MEDIAN, REQ_POP, REQ_PUSH, REQ_PUSH, REQ_MEDIAN
  };

  stack_with_median_query DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // lower median from the tallies: find the block, then the value inside it
  function automatic logic [DATA_W-1:0] lower_median();
    int unsigned rank;
    int unsigned seen;
    int unsigned blk;
    int unsigned base;
    rank = (held_vals.size() + 1) / 2;
    seen = 0;
    blk  = 0;
    while (blk < NUM_BLOCKS && seen + blk_tally[blk] < rank) begin
      seen += blk_tally[blk];
      blk++;
    end
    if (blk >= NUM_BLOCKS) return '0;
    base = blk * BLK_SIZE;
    for (int unsigned i = 0; i < BLK_SIZE; i++) begin
      if (seen + val_tally[base + i] >= rank) return DATA_W'(base + i);
      seen += val_tally[base + i];
    end
    return '0;
  endfunction

  // reply of one request, updating the shadow stack
  function automatic reply_t compute_reply(input logic [REQ_W-1:0] req,
                                           input logic [DATA_W-1:0] val);
    reply_t                r;
    logic [VALUE_BITS-1:0] v;
    r = '{value: '0, stat: STAT_OK};
    v = VALUE_BITS'(val);
    case (req)
      REQ_PUSH: begin
        if (held_vals.size() >= STACK_DEPTH) begin
          r.stat = STAT_FULL;
        end else begin
          held_vals.push_back(DATA_W'(v));
          val_tally[v]++;
          blk_tally[v >> BLK_SHIFT]++;
        end
      end
      REQ_POP: begin
        if (held_vals.size() == 0) begin
          r.stat = STAT_EMPTY;
        end else begin
          v = VALUE_BITS'(held_vals.pop_back());
          val_tally[v]--;
          blk_tally[v >> BLK_SHIFT]--;
          r.value = DATA_W'(v);
        end
      end
      REQ_MEDIAN: begin
        if (held_vals.size() == 0) r.stat = STAT_EMPTY;
        else r.value = lower_median();
      end
      default: ;
    endcase
    return r;
  endfunction

  // value mix: random, repeated, one block, block edges
  function automatic logic [DATA_W-1:0] pick_value(input logic [DATA_W-1:0] hot,
                                                   input logic [BLOCK_BITS-1:0] hot_blk);
    logic [BLK_SHIFT-1:0] low;
    low = BLK_SHIFT'($urandom);
    case ($urandom_range(0, 9))
      5, 6:    return hot;
      7:       return DATA_W'({hot_blk, low});
      8: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return DATA_W'({BLOCK_BITS'($urandom), {BLK_SHIFT{1'b0}}});
          default: return DATA_W'({BLOCK_BITS'($urandom), {BLK_SHIFT{1'b1}}});
        endcase
      end
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // one request on the input channel, with an optional gap before it
  task automatic issue_req(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val,
                           input logic known, input reply_t fixed);
    reply_t r;
    if (in_idle_pct != 0 && $urandom_range(1, 100) <= in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = compute_reply(req, val);
    pending_replies.push_back(known ? fixed : r);
  endtask

  // hold the input until every reply is back
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // receiver: random backpressure and one long hold
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYC) @(posedge clk);
        long_hold = 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // reply checker
  always @(posedge clk) begin : reply_chk
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: reply with none pending: value %h status %0d",
                 $time, out_tdata, out_tuser);
        mismatch_cnt++;
      end else begin
        want = pending_replies.pop_front();
        if (out_tdata !== want.value) begin
          $display("%0t: result_value expected %h actual %h", $time, want.value, out_tdata);
          mismatch_cnt++;
        end
        if (out_tuser !== want.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, want.stat, out_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #80_000_000;
    $display("stack_with_median_query verification failed");
    $finish;
  end

  // stimulus
  initial begin
    reply_t                fixed;
    logic [REQ_W-1:0]      req;
    logic [DATA_W-1:0]     hot;
    logic [BLOCK_BITS-1:0] hot_blk;
    int                    made;
    int                    span;
    int                    push_w;
    int                    pick;
    int                    pops;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows
    foreach (dir_rows[i]) begin
      fixed = '{value: dir_rows[i].exp_res, stat: dir_rows[i].exp_stat};
      issue_req(dir_rows[i].req, dir_rows[i].value, dir_rows[i].known, fixed);
    end

    // fill to the top, poke the full stack, then pop back to empty
    in_idle_pct  = 2;
    out_idle_pct = 2;
    hot     = DATA_W'($urandom);
    hot_blk = BLOCK_BITS'($urandom);
    while (held_vals.size() < STACK_DEPTH)
      issue_req(REQ_PUSH, pick_value(hot, hot_blk), 1'b0, '0);
    foreach (full_probe[i])
      issue_req(full_probe[i], DATA_W'($urandom), 1'b0, '0);
    pops = 0;
    while (held_vals.size() > 0) begin
      issue_req(REQ_POP, DATA_W'($urandom), 1'b0, '0);
      pops++;
      if (pops % 500 == 0) issue_req(REQ_MEDIAN, DATA_W'($urandom), 1'b0, '0);
    end

    // random epochs: growing, shrinking and balanced mixes
    made = 0;
    while (made < RAND_ITEMS) begin
      span = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       push_w = 75;
        1:       push_w = 20;
        default: push_w = 45;
      endcase
      hot     = DATA_W'($urandom);
      hot_blk = BLOCK_BITS'($urandom);
      if (made < RAND_ITEMS - TAIL_ITEMS) begin
        in_idle_pct  = 15 * $urandom_range(0, 2);
        out_idle_pct = 15 * $urandom_range(0, 2);
      end
      repeat (span) begin
        // quiet tail with no idling on either side
        if (made == RAND_ITEMS - TAIL_ITEMS) begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
        if (made == LONG_HOLD_AT) long_hold = 1'b1;
        if (made == PAUSE_AT) drain_replies();
        pick = $urandom_range(0, 99);
        if (pick < push_w) req = REQ_PUSH;
        else if (pick < push_w + (96 - push_w) / 2) req = REQ_POP;
        else if (pick < 96) req = REQ_MEDIAN;
        else req = REQ_SPARE;
        issue_req(req, pick_value(hot, hot_blk), 1'b0, '0);
        made++;
      end
    end

    // wrap up
    drain_replies();
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("stack_with_median_query verification clean");
    end else begin
      $display("stack_with_median_query verification failed");
    end
    $finish;
  end

endmodule
